// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the stereo slew limiter: one form that is muted
// while reset is held, one that also checks behaviour during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk outside reset
`define SSLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset included
`define SSLM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sslm_pkg.sv -----
// ----------------------------------------------------------------------------
// sslm_pkg
// Widths, register indexes, reset values and request/result types of the
// stereo slew limiter and monitor.
// ----------------------------------------------------------------------------
package sslm_pkg;

  // Sample and counter widths
  localparam int SAMPLE_WIDTH    = 24;
  localparam int COUNT_WIDTH     = 32;
  localparam int DELTA_WIDTH     = SAMPLE_WIDTH - 1;
  localparam int CFG_DATA_WIDTH  = SAMPLE_WIDTH;
  localparam int CFG_INDEX_WIDTH = 1;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLEW_MAX_DELTA = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_JUMP_THRESHOLD = 1'd1;

  // Register reset values (Q3.20 and Q4.20)
  localparam logic [DELTA_WIDTH-1:0]  SLEW_MAX_DELTA_RESET = 23'd859832;
  localparam logic [SAMPLE_WIDTH-1:0] JUMP_THRESHOLD_RESET = 24'd262144;

  // Sample range limits
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Request commands
  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_CLEAR = 1'b1
  } command_t;

  // One request: a stereo frame or a clear
  typedef struct packed {
    command_t                        command;
    logic signed [SAMPLE_WIDTH-1:0]  left_sample;
    logic signed [SAMPLE_WIDTH-1:0]  right_sample;
    logic                            left_not_finite;
    logic                            right_not_finite;
  } frame_t;

  // One result
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0]  left_out;
    logic signed [SAMPLE_WIDTH-1:0]  right_out;
    logic signed [SAMPLE_WIDTH-1:0]  mono_out;
    logic        [SAMPLE_WIDTH-1:0]  largest_step;
    logic        [COUNT_WIDTH-1:0]   jump_total;
    logic        [COUNT_WIDTH-1:0]   bad_sample_total;
  } result_t;

endpackage

// ----- rtl/sslm_frame_if.sv -----
// ----------------------------------------------------------------------------
// sslm_frame_if
// Valid/ready channel that carries stereo frame requests into the block.
// ----------------------------------------------------------------------------
interface sslm_frame_if import sslm_pkg::*; ();

  logic   valid;
  logic   ready;
  frame_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/sslm_result_if.sv -----
// ----------------------------------------------------------------------------
// sslm_result_if
// Valid/ready channel that carries limited samples and statistics out.
// ----------------------------------------------------------------------------
interface sslm_result_if import sslm_pkg::*; ();

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/stereo_slew_limiter_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_slew_limiter_monitor_unit
// Stereo slew-rate limiter with mono mix, peak step and jump/bad counters.
// ----------------------------------------------------------------------------
// Usage:
//   frames  : requests in (valid/ready). A frame request carries both
//             samples and their not-finite flags; a clear request wipes the
//             history and statistics and returns an all-zero result.
//   results : one result per request, in order (valid/ready).
//   wr_en / wr_index / wr_data : register writes, taken on any edge with
//             wr_en high; write only while no request is in flight.
// Path: a request passes the request register, then the result register.
//   Throughput: one request per cycle while results.ready is high; the history
//   and counters update as a request moves into the result register, so the
//   next request sees them in the following cycle.
// Reset: both stages empty, history and statistics zero, registers at
//   their defaults. No clearing pass is needed.
// Stall: while results.ready is low the result register holds, the request
//   register fills, and frames.ready drops once both are occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_slew_limiter_monitor_unit import sslm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  sslm_frame_if.sink                 frames,
  sslm_result_if.source              results,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [CFG_DATA_WIDTH-1:0]  wr_data
);

  // Configuration registers
  logic [DELTA_WIDTH-1:0]  slew_max_delta;
  logic [SAMPLE_WIDTH-1:0] jump_threshold;

  // History and statistics
  logic signed [SAMPLE_WIDTH-1:0] last_left;
  logic signed [SAMPLE_WIDTH-1:0] last_right;
  logic signed [SAMPLE_WIDTH-1:0] last_mono;
  logic                           history_valid;
  logic [SAMPLE_WIDTH-1:0]        peak_step;
  logic [COUNT_WIDTH-1:0]         jump_counter;
  logic [COUNT_WIDTH-1:0]         bad_counter;

  // Pipeline registers
  logic    req_valid;
  frame_t  req;
  logic    out_valid;
  result_t out_data;
  logic    advance;

  // Datapath signals
  logic signed [SAMPLE_WIDTH-1:0] left_clean;
  logic signed [SAMPLE_WIDTH-1:0] right_clean;
  logic signed [SAMPLE_WIDTH-1:0] left_next;
  logic signed [SAMPLE_WIDTH-1:0] right_next;
  logic signed [SAMPLE_WIDTH:0]   mono_sum;
  logic signed [SAMPLE_WIDTH-1:0] mono_next;
  logic signed [SAMPLE_WIDTH:0]   step_diff;
  logic signed [SAMPLE_WIDTH:0]   step_abs;
  logic [SAMPLE_WIDTH-1:0]        step_mag;
  logic [1:0]                     bad_inc;
  logic [COUNT_WIDTH:0]           bad_sum;
  logic [SAMPLE_WIDTH-1:0]        peak_next;
  logic [COUNT_WIDTH-1:0]         jump_next;
  logic [COUNT_WIDTH-1:0]         bad_next;
  result_t                        res;

  // Clamp a one-bit-wider value to the sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [SAMPLE_WIDTH:0] v
  );
    logic signed [SAMPLE_WIDTH-1:0] r;
    begin
      if (v[SAMPLE_WIDTH] != v[SAMPLE_WIDTH-1]) begin
        r = v[SAMPLE_WIDTH] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
        r = v[SAMPLE_WIDTH-1:0];
      end
      return r;
    end
  endfunction

  // Move at most m away from prev; both bounds computed in parallel
  function automatic logic signed [SAMPLE_WIDTH-1:0] limit_step(
    input logic signed [SAMPLE_WIDTH-1:0] now,
    input logic signed [SAMPLE_WIDTH-1:0] prev,
    input logic        [DELTA_WIDTH-1:0]  m
  );
    logic signed [SAMPLE_WIDTH:0] d;
    logic signed [SAMPLE_WIDTH:0] mx;
    logic signed [SAMPLE_WIDTH:0] up;
    logic signed [SAMPLE_WIDTH:0] dn;
    logic signed [SAMPLE_WIDTH-1:0] r;
    begin
      d  = {now[SAMPLE_WIDTH-1], now} - {prev[SAMPLE_WIDTH-1], prev};
      mx = {2'b00, m};
      up = {prev[SAMPLE_WIDTH-1], prev} + mx;
      dn = {prev[SAMPLE_WIDTH-1], prev} - mx;
      if (d > mx) begin
        r = sat_sample(up);
      end else if (d < -mx) begin
        r = sat_sample(dn);
      end else begin
        r = now;
      end
      return r;
    end
  endfunction

  // Handshake: advance the request into the result register when it is free
  assign advance       = req_valid && (!out_valid || results.ready);
  assign frames.ready  = !req_valid || advance;
  assign results.valid = out_valid;
  assign results.payload = out_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slew_max_delta <= SLEW_MAX_DELTA_RESET;
      jump_threshold <= JUMP_THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SLEW_MAX_DELTA: slew_max_delta <= wr_data[DELTA_WIDTH-1:0];
        REG_JUMP_THRESHOLD: jump_threshold <= wr_data[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Replace non-finite samples and limit against the history
  always_comb begin
    left_clean  = req.left_not_finite  ? '0 : req.left_sample;
    right_clean = req.right_not_finite ? '0 : req.right_sample;
    if (history_valid) begin
      left_next  = limit_step(left_clean, last_left, slew_max_delta);
      right_next = limit_step(right_clean, last_right, slew_max_delta);
    end else begin
      left_next  = left_clean;
      right_next = right_clean;
    end
  end

  // Mono mix with floor halving, and the absolute mono step
  always_comb begin
    mono_sum  = {left_next[SAMPLE_WIDTH-1], left_next}
              + {right_next[SAMPLE_WIDTH-1], right_next};
    mono_next = mono_sum[SAMPLE_WIDTH:1];
    step_diff = {mono_next[SAMPLE_WIDTH-1], mono_next}
              - {last_mono[SAMPLE_WIDTH-1], last_mono};
    step_abs  = step_diff[SAMPLE_WIDTH] ? -step_diff : step_diff;
    step_mag  = step_abs[SAMPLE_WIDTH-1:0];
  end

  // Statistics: peak step, jump count, bad-sample count (saturating)
  always_comb begin
    peak_next = peak_step;
    jump_next = jump_counter;
    if (history_valid) begin
      if (step_mag > peak_step) begin
        peak_next = step_mag;
      end
      if ((step_mag > jump_threshold) && (jump_counter != {COUNT_WIDTH{1'b1}})) begin
        jump_next = jump_counter + 1'b1;
      end
    end
    bad_inc  = {1'b0, req.left_not_finite} + {1'b0, req.right_not_finite};
    bad_sum  = {1'b0, bad_counter} + {{(COUNT_WIDTH-1){1'b0}}, bad_inc};
    bad_next = bad_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : bad_sum[COUNT_WIDTH-1:0];
  end

  // Assemble the result; a clear gives all zeros
  always_comb begin
    if (req.command == CMD_CLEAR) begin
      res = '0;
    end else begin
      res.left_out         = left_next;
      res.right_out        = right_next;
      res.mono_out         = mono_next;
      res.largest_step     = peak_next;
      res.jump_total       = jump_next;
      res.bad_sample_total = bad_next;
    end
  end

  // Request register: load on accept, drop once advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (frames.valid && frames.ready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      req <= frames.payload;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  // History and statistics update as the request retires
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left     <= '0;
      last_right    <= '0;
      last_mono     <= '0;
      history_valid <= 1'b0;
      peak_step     <= '0;
      jump_counter  <= '0;
      bad_counter   <= '0;
    end else if (advance) begin
      if (req.command == CMD_CLEAR) begin
        last_left     <= '0;
        last_right    <= '0;
        last_mono     <= '0;
        history_valid <= 1'b0;
        peak_step     <= '0;
        jump_counter  <= '0;
        bad_counter   <= '0;
      end else begin
        last_left     <= left_next;
        last_right    <= right_next;
        last_mono     <= mono_next;
        history_valid <= 1'b1;
        peak_step     <= peak_next;
        jump_counter  <= jump_next;
        bad_counter   <= bad_next;
      end
    end
  end

  // Checks
  `SSLM_ASSERT_RST(a_reset_empty, rst |=> (!req_valid && !out_valid),
                   "pipeline not empty after reset")
  `SSLM_ASSERT(a_clear_wipes, (advance && (req.command == CMD_CLEAR)) |=>
               (!history_valid && (jump_counter == '0) && (bad_counter == '0)
                && (peak_step == '0)),
               "clear did not wipe history")
  `SSLM_ASSERT(a_result_matches_state, advance |=>
               ((out_data.jump_total == jump_counter)
                && (out_data.bad_sample_total == bad_counter)
                && (out_data.largest_step == peak_step)),
               "result disagrees with statistics")
  `SSLM_ASSERT(a_bad_monotonic, (advance && (req.command == CMD_FRAME)) |=>
               (bad_counter >= $past(bad_counter)),
               "bad-sample count went down")

endmodule

// ----- bench/sslm_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sslm_frame_checker
// Watches the request and result channels of the stereo slew limiter,
// predicts every result from its own copy of the history, statistics and
// registers, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module sslm_frame_checker import sslm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  sslm_frame_if                      frames,
  sslm_result_if                     results,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
  output int                         fail_count,
  output int                         in_flight
);

  // Two guard bits cover sums and differences of two samples
  typedef logic signed [SAMPLE_WIDTH+1:0] wide_t;

  // Register copies
  logic [DELTA_WIDTH-1:0]  slew_limit;
  logic [SAMPLE_WIDTH-1:0] jump_level;

  // History and statistics
  wide_t                   prev_left;
  wide_t                   prev_right;
  wide_t                   prev_mono;
  logic                    have_history;
  logic [SAMPLE_WIDTH-1:0] peak_mono_step;
  logic [COUNT_WIDTH-1:0]  jump_count;
  logic [COUNT_WIDTH-1:0]  bad_count;

  result_t limited_outputs[$];
  int      mismatch_count = 0;

  assign fail_count = mismatch_count;

  // Wipe history and statistics
  function automatic void clear_history();
    prev_left      = '0;
    prev_right     = '0;
    prev_mono      = '0;
    have_history   = 1'b0;
    peak_mono_step = '0;
    jump_count     = '0;
    bad_count      = '0;
  endfunction

  // Hold a channel within slew_limit of its previous output, saturating
  function automatic wide_t limit_channel(wide_t now, wide_t prev);
    wide_t lim;
    wide_t diff;
    wide_t hi;
    wide_t lo;
    wide_t moved;
    lim  = $signed({3'b000, slew_limit});
    diff = now - prev;
    hi   = SAMPLE_MAX;
    lo   = SAMPLE_MIN;
    if (diff > lim) begin
      moved = prev + lim;
    end else if (diff < -lim) begin
      moved = prev - lim;
    end else begin
      return now;
    end
    if (moved > hi) return hi;
    if (moved < lo) return lo;
    return moved;
  endfunction

  // Advance the history by one request and return its result
  function automatic result_t slew_limit_frame(frame_t f);
    result_t r;
    wide_t   l;
    wide_t   rt;
    wide_t   mono;
    wide_t   step;
    r = '0;
    if (f.command == CMD_CLEAR) begin
      clear_history();
      return r;
    end
    l  = f.left_sample;
    rt = f.right_sample;
    if (f.left_not_finite) begin
      l = '0;
      if (bad_count != '1) bad_count = bad_count + 1'b1;
    end
    if (f.right_not_finite) begin
      rt = '0;
      if (bad_count != '1) bad_count = bad_count + 1'b1;
    end
    if (have_history) begin
      l  = limit_channel(l, prev_left);
      rt = limit_channel(rt, prev_right);
    end
    prev_left  = l;
    prev_right = rt;
    // floor of the half sum
    mono = (l + rt) >>> 1;
    if (have_history) begin
      step = mono - prev_mono;
      if (step < 0) step = -step;
      if (step > $signed({2'b00, peak_mono_step})) peak_mono_step = step[SAMPLE_WIDTH-1:0];
      if (step > $signed({2'b00, jump_level}) && jump_count != '1) begin
        jump_count = jump_count + 1'b1;
      end
    end
    prev_mono    = mono;
    have_history = 1'b1;
    r.left_out         = l[SAMPLE_WIDTH-1:0];
    r.right_out        = rt[SAMPLE_WIDTH-1:0];
    r.mono_out         = mono[SAMPLE_WIDTH-1:0];
    r.largest_step     = peak_mono_step;
    r.jump_total       = jump_count;
    r.bad_sample_total = bad_count;
    return r;
  endfunction

  // Report every field that differs
  function automatic void compare_result(result_t got, result_t want);
    if (got.left_out !== want.left_out) begin
      $error("left_out: expected %0d, actual %0d", want.left_out, got.left_out);
      mismatch_count++;
    end
    if (got.right_out !== want.right_out) begin
      $error("right_out: expected %0d, actual %0d", want.right_out, got.right_out);
      mismatch_count++;
    end
    if (got.mono_out !== want.mono_out) begin
      $error("mono_out: expected %0d, actual %0d", want.mono_out, got.mono_out);
      mismatch_count++;
    end
    if (got.largest_step !== want.largest_step) begin
      $error("largest_step: expected %0d, actual %0d", want.largest_step, got.largest_step);
      mismatch_count++;
    end
    if (got.jump_total !== want.jump_total) begin
      $error("jump_total: expected %0d, actual %0d", want.jump_total, got.jump_total);
      mismatch_count++;
    end
    if (got.bad_sample_total !== want.bad_sample_total) begin
      $error("bad_sample_total: expected %0d, actual %0d",
             want.bad_sample_total, got.bad_sample_total);
      mismatch_count++;
    end
  endfunction

  // Track writes, predict accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      clear_history();
      slew_limit = SLEW_MAX_DELTA_RESET;
      jump_level = JUMP_THRESHOLD_RESET;
      limited_outputs.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_SLEW_MAX_DELTA) begin
          slew_limit = wr_data[DELTA_WIDTH-1:0];
        end else if (wr_index == REG_JUMP_THRESHOLD) begin
          jump_level = wr_data[SAMPLE_WIDTH-1:0];
        end
      end
      // a result never belongs to the request taken at the same edge
      if (results.valid && results.ready) begin
        if (limited_outputs.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          compare_result(results.payload, limited_outputs.pop_front());
        end
      end
      if (frames.valid && frames.ready) begin
        limited_outputs.push_back(slew_limit_frame(frames.payload));
      end
    end
    in_flight <= limited_outputs.size();
  end

endmodule

// ----- bench/tb_stereo_slew_limiter_monitor_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_slew_limiter_monitor_unit
// Drives frame and clear requests through the stereo slew limiter under
// several register settings, with random idling on both channels and a long
// result stall, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module tb_stereo_slew_limiter_monitor_unit;
  import sslm_pkg::*;

  localparam int          HOLD_CYCLES  = 80;
  localparam int          DRAIN_PAUSE  = 4;
  localparam int          PHASE_FRAMES = 100;
  localparam int unsigned LIMIT_NS     = 5_000_000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       wr_en;
  logic [CFG_INDEX_WIDTH-1:0] wr_index;
  logic [CFG_DATA_WIDTH-1:0]  wr_data;
  int                         fail_count;
  int                         in_flight;

  // Idling controls for the sender (gaps_on) and the receiver (stall_on, hold_results)
  logic gaps_on      = 1'b0;
  logic stall_on     = 1'b0;
  logic hold_results = 1'b0;

  logic signed [SAMPLE_WIDTH-1:0] walk_left  = '0;
  logic signed [SAMPLE_WIDTH-1:0] walk_right = '0;

  sslm_frame_if  frames_ch ();
  sslm_result_if results_ch ();

  stereo_slew_limiter_monitor_unit dut (
    .clk      (clk),
    .rst      (rst),
    .frames   (frames_ch),
    .results  (results_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  sslm_frame_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .frames     (frames_ch),
    .results    (results_ch),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic frame_t make_frame(command_t cmd, logic signed [SAMPLE_WIDTH-1:0] l,
                                        logic signed [SAMPLE_WIDTH-1:0] r,
                                        logic lbad, logic rbad);
    frame_t f;
    f.command          = cmd;
    f.left_sample      = l;
    f.right_sample     = r;
    f.left_not_finite  = lbad;
    f.right_not_finite = rbad;
    return f;
  endfunction

  // Extremes, full-range noise, or a small move from the last value
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(
      logic signed [SAMPLE_WIDTH-1:0] near);
    logic signed [SAMPLE_WIDTH-1:0] s;
    case ($urandom_range(0, 7))
      0: s = SAMPLE_MAX;
      1: s = SAMPLE_MIN;
      2, 3: s = SAMPLE_WIDTH'($urandom);
      default: s = near + SAMPLE_WIDTH'($urandom_range(0, 131072)) - 24'd65536;
    endcase
    return s;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_frame(frame_t f);
    int unsigned gap;
    frames_ch.valid   <= 1'b1;
    frames_ch.payload <= f;
    do @(posedge clk); while (!frames_ch.ready);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = gap_length();
      frames_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    frame_t f;
    if ($urandom_range(0, 39) == 0) begin
      f = make_frame(CMD_CLEAR, SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom),
                     1'($urandom), 1'($urandom));
      walk_left  = '0;
      walk_right = '0;
    end else begin
      f = make_frame(CMD_FRAME, pick_sample(walk_left), pick_sample(walk_right),
                     $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
      walk_left  = f.left_sample;
      walk_right = f.right_sample;
    end
    send_frame(f);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    frames_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    results_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_results && !hold_done) begin
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        results_ch.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        results_ch.ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
        results_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    frames_ch.valid   <= 1'b0;
    frames_ch.payload <= '0;
    wr_en             <= 1'b0;
    wr_index          <= '0;
    wr_data           <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: extremes, bad flags, clear with flags set
    send_frame(make_frame(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0));
    send_frame(make_frame(CMD_FRAME, 24'h123456, -24'sd1, 1'b0, 1'b1));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1));
    send_frame(make_frame(CMD_CLEAR, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b1));
    send_frame(make_frame(CMD_FRAME, -24'sd1, 24'sd1, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, '0, '0, 1'b0, 1'b0));
    drain();

    // Widest limit (upper data bit ignored), lowest threshold
    write_reg(REG_SLEW_MAX_DELTA, '1);
    write_reg(REG_JUMP_THRESHOLD, '0);
    send_frame(make_frame(CMD_FRAME, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0));
    drain();

    // Frozen channels, highest threshold
    write_reg(REG_SLEW_MAX_DELTA, '0);
    write_reg(REG_JUMP_THRESHOLD, '1);
    send_frame(make_frame(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0));
    send_frame(make_frame(CMD_CLEAR, '0, '0, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0));
    send_frame(make_frame(CMD_FRAME, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b0));
    drain();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SLEW_MAX_DELTA, CFG_DATA_WIDTH'($urandom_range(1, 1 << 18)));
          write_reg(REG_JUMP_THRESHOLD, CFG_DATA_WIDTH'($urandom_range(0, 1 << 20)));
        end
        1: begin
          write_reg(REG_SLEW_MAX_DELTA, '1);
          write_reg(REG_JUMP_THRESHOLD, '0);
        end
        2: begin
          write_reg(REG_SLEW_MAX_DELTA, '0);
          write_reg(REG_JUMP_THRESHOLD, '1);
        end
        default: begin
          write_reg(REG_SLEW_MAX_DELTA, CFG_DATA_WIDTH'($urandom));
          write_reg(REG_JUMP_THRESHOLD, CFG_DATA_WIDTH'($urandom));
        end
      endcase
      gaps_on  = (phase != 0);
      stall_on = (phase != 0);

      // Hold results off while requests keep coming, so the block backs up
      if (phase == 1) begin
        gaps_on      = 1'b0;
        hold_results = 1'b1;
        repeat (12) send_random();
        drain();
        gaps_on = 1'b1;
      end

      repeat (PHASE_FRAMES) send_random();
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_stereo_slew_limiter_monitor_unit passed");
    end else begin
      $display("tb_stereo_slew_limiter_monitor_unit failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_NS);
    $display("tb_stereo_slew_limiter_monitor_unit failed");
    $finish;
  end

endmodule
